// ===== design/dcsp_pkg.sv =====
// Shared types and constants for the divisor count, sum and primality unit.
`timescale 1ns / 1ps

package dcsp_pkg;

	localparam int NUMBER_WIDTH_DEF = 32;
	localparam int COUNT_W = 11;
	localparam int SUM_W = 35;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;
	localparam int SMALLEST_PRIME = 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_STEP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic accum;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic div_last;
		logic d_le_q;
	} status_t;

endpackage

// ===== design/dcsp_datapath.sv =====
// Datapath: serial restoring divider, trial divisor, accumulators and result registers.
`timescale 1ns / 1ps

module dcsp_datapath #(
	parameter int NUMBER_WIDTH = dcsp_pkg::NUMBER_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dcsp_pkg::cmd_t              cmd,
	output dcsp_pkg::status_t           status,
	input  logic [NUMBER_WIDTH-1:0]     number,
	output logic [dcsp_pkg::COUNT_W-1:0] divisor_count,
	output logic [dcsp_pkg::SUM_W-1:0]   divisor_sum,
	output logic                        is_prime
);
	import dcsp_pkg::*;

	localparam int W = NUMBER_WIDTH;
	localparam int CW = $clog2(W);
	localparam int SW = ((W > SUM_W) ? W : SUM_W) + 2;

	logic [W-1:0]       n_q;
	logic [W-1:0]       d_q;
	logic [W-1:0]       rem_q;
	logic [W-1:0]       quo_q;
	logic [CW-1:0]      bit_q;
	logic [COUNT_W-1:0] count_q;
	logic [SUM_W-1:0]   sum_q;
	logic               small_q;
	logic               busy_q;

	logic [W:0]         rem_ext;
	logic               ge;
	logic [W:0]         rem_sub;
	logic               hit;
	logic               square;
	logic [COUNT_W:0]   count_tot;
	logic [SW-1:0]      sum_tot;
	logic [COUNT_W-1:0] count_next;
	logic [SUM_W-1:0]   sum_next;

	// one quotient bit per cycle while div_step is asserted
	assign rem_ext = {rem_q, quo_q[W-1]};
	assign ge      = rem_ext >= {1'b0, d_q};
	assign rem_sub = rem_ext - {1'b0, d_q};

	assign hit    = (rem_q == '0);
	assign square = (d_q == quo_q);

	assign count_tot = {1'b0, count_q} + (square ? (COUNT_W+1)'(1) : (COUNT_W+1)'(2));
	assign sum_tot   = SW'(sum_q) + SW'(d_q) + (square ? SW'(0) : SW'(quo_q));

	always_comb begin
		count_next = (count_tot > (COUNT_W+1)'(COUNT_MAX)) ? COUNT_MAX
			: count_tot[COUNT_W-1:0];
		sum_next = (sum_tot > SW'(SUM_MAX)) ? SUM_MAX : sum_tot[SUM_W-1:0];
	end

	assign status.div_last = (bit_q == CW'(W-1));
	assign status.d_le_q   = (d_q <= quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (cmd.load) begin
			busy_q <= 1'b1;
		end else if (cmd.publish) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q     <= number;
			d_q     <= W'(1);
			rem_q   <= '0;
			quo_q   <= number;
			bit_q   <= '0;
			count_q <= '0;
			sum_q   <= '0;
			small_q <= 1'b0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? rem_sub[W-1:0] : rem_ext[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
			bit_q <= bit_q + CW'(1);
		end else if (cmd.accum) begin
			if (hit) begin
				count_q <= count_next;
				sum_q   <= sum_next;
				if (d_q >= W'(SMALLEST_PRIME)) begin
					small_q <= 1'b1;
				end
			end
			// advance to the next trial divisor and restart the divider
			d_q   <= d_q + W'(1);
			rem_q <= '0;
			quo_q <= n_q;
			bit_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish && busy_q) begin
			divisor_count <= count_q;
			divisor_sum   <= sum_q;
			is_prime      <= (n_q >= W'(SMALLEST_PRIME)) && !small_q;
		end
	end

endmodule

// ===== design/dcsp_controller.sv =====
// Controller: state machine that sequences trial divisions and the result handshake.
`timescale 1ns / 1ps

module dcsp_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  dcsp_pkg::status_t   status,
	output dcsp_pkg::cmd_t      cmd
);
	import dcsp_pkg::*;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_DIV;
				end
			end
			ST_DIV: begin
				if (status.div_last) begin
					state_next = ST_STEP;
				end
			end
			ST_STEP: begin
				state_next = status.d_le_q ? ST_DIV : ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_STEP: begin
				cmd.accum = status.d_le_q;
			end
			ST_DONE: begin
				cmd.publish = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== design/divisor_count_sum_prime_unit.sv =====
// Each trial divisor runs through the bit-serial divider, followed by an update in ST_STEP.
// One word at a time: the next word is taken once the result is registered.
// The output register holds a result while the next word is already in work.
// Reset (arst_n low, asynchronous) returns the controller to idle and drops out_valid.
`timescale 1ns / 1ps

module divisor_count_sum_prime_unit #(
	parameter int NUMBER_WIDTH = dcsp_pkg::NUMBER_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [NUMBER_WIDTH-1:0]      number,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [dcsp_pkg::COUNT_W-1:0] divisor_count,
	output logic [dcsp_pkg::SUM_W-1:0]   divisor_sum,
	output logic                         is_prime
);
	import dcsp_pkg::*;

	cmd_t    cmd;
	status_t status;

	dcsp_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	dcsp_datapath #(
		.NUMBER_WIDTH (NUMBER_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.number        (number),
		.divisor_count (divisor_count),
		.divisor_sum   (divisor_sum),
		.is_prime      (is_prime)
	);

endmodule

// ===== tb/divisor_count_sum_prime_unit_tb.sv =====
// Self-checking testbench for the divisor count, divisor sum and primality unit.
`timescale 1ns / 1ps

module divisor_count_sum_prime_unit_tb;
	import dcsp_pkg::*;

	localparam int NW = NUMBER_WIDTH_DEF;
	// The slowest run here is dominated by the all-ones word.
	localparam longint CYCLE_LIMIT = 15_000_000;
	localparam int TAIL_CYCLES = 200;
	localparam int LONG_HOLD = 3000;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [SUM_W-1:0]   total;
		logic               prime;
	} divisor_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [NW-1:0]      number = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [COUNT_W-1:0] divisor_count;
	logic [SUM_W-1:0]   divisor_sum;
	logic               is_prime;

	divisor_result_t expected_results[$];
	int     error_count = 0;
	longint cycle_count = 0;
	bit     idling_on = 1'b1;
	int     hold_request = 0;
	int     hold_left = 0;
	int     stall_left = 0;

	divisor_count_sum_prime_unit #(
		.NUMBER_WIDTH(NW)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.number       (number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.divisor_count(divisor_count),
		.divisor_sum  (divisor_sum),
		.is_prime     (is_prime)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			expected_results.size());
		$display("Simulation FAILED");
		$finish;
	end

	function automatic longint unsigned add_capped(longint unsigned a, longint unsigned b,
			longint unsigned cap);
		longint unsigned s;
		s = a + b;
		if (s < a || s > cap)
			return cap;
		return s;
	endfunction

	// Trial division over d while d <= n/d; a square root pair counts once.
	function automatic divisor_result_t predict_divisors(logic [NW-1:0] n_word);
		longint unsigned n, d, q, count, total;
		bit              has_small;
		divisor_result_t r;
		n = n_word;
		count = 0;
		total = 0;
		has_small = 1'b0;
		for (d = 1; d <= n / d; d++) begin
			q = n / d;
			if (n % d == 0) begin
				if (d >= SMALLEST_PRIME)
					has_small = 1'b1;
				if (d == q) begin
					count = add_capped(count, 1, COUNT_MAX);
					total = add_capped(total, d, SUM_MAX);
				end else begin
					count = add_capped(count, 2, COUNT_MAX);
					total = add_capped(total, d, SUM_MAX);
					total = add_capped(total, q, SUM_MAX);
				end
			end
		end
		r.count = count[COUNT_W-1:0];
		r.total = total[SUM_W-1:0];
		r.prime = (n >= SMALLEST_PRIME) && !has_small;
		return r;
	endfunction

	task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, field, got, want);
		error_count++;
	endtask

	// Result checker: compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		divisor_result_t want;
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, count", divisor_count, 0);
			end else begin
				want = expected_results.pop_front();
				if (divisor_count !== want.count)
					report_mismatch("divisor_count", divisor_count, want.count);
				if (divisor_sum !== want.total)
					report_mismatch("divisor_sum", divisor_sum, want.total);
				if (is_prime !== want.prime)
					report_mismatch("is_prime", is_prime, want.prime);
			end
		end
	end

	// Receiver: long hold on request, otherwise short random stall bursts while idling_on is set.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (idling_on && stall_left == 0 && $urandom_range(0, 3) == 0)
				stall_left = $urandom_range(1, 7);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one word; keep valid high across back-to-back words unless a random idle gap is inserted.
	task automatic send_number(logic [NW-1:0] n);
		if (idling_on && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		number <= n;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_results = {expected_results, predict_divisors(n)};
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_special_values();
		logic [NW-1:0] list[$];
		list = '{0, 1, 2, 3, 4, 6, 9, 12, 16, 25, 36, 97, 1000000};
		foreach (list[i]) send_number(list[i]);
		wait_results_drained();
	endtask

	task automatic test_field_extremes();
		logic [NW-1:0] list[$];
		list = '{65521, 65536, 32'h00FF_FFFF, 32'h0100_0000, 32'hFFFF_FFFF};
		foreach (list[i]) send_number(list[i]);
		wait_results_drained();
	endtask

	// Keep widths small: cost grows with the square root of the word.
	task automatic test_random_numbers(int n_items);
		int            bits;
		int            a;
		int            b;
		logic [NW-1:0] n;
		for (int i = 0; i < n_items; i++) begin
			case ($urandom_range(0, 9)) inside
				[0:5]: begin
					bits = $urandom_range(1, 16);
					n = $urandom & ((32'h1 << bits) - 1);
				end
				6: begin
					bits = $urandom_range(17, 20);
					n = $urandom & ((32'h1 << bits) - 1);
				end
				7: begin
					a = $urandom_range(0, 255);
					n = a * a;
				end
				8: n = $urandom_range(0, 1023);
				default: begin
					a = $urandom_range(1, 255);
					b = $urandom_range(1, 255);
					n = a * b;
				end
			endcase
			send_number(n);
		end
		wait_results_drained();
	endtask

	// Hold the output long enough for the unit to fill and refuse input.
	task automatic test_output_backpressure();
		hold_request = LONG_HOLD;
		for (int i = 0; i < 8; i++) send_number($urandom_range(0, 255));
		wait_results_drained();
	endtask

	task automatic test_steady_stream();
		idling_on = 1'b0;
		for (int i = 0; i < 20; i++) send_number($urandom_range(0, 4095));
		wait_results_drained();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_values();
		test_field_extremes();
		test_random_numbers(60);
		test_output_backpressure();
		test_steady_stream();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
